>>> sv/bvo_pkg.sv
package bvo_pkg;

    localparam int ELEM_BITS   = 16;
    localparam int MAG_BITS    = ELEM_BITS;
    localparam int ACC_BITS    = 43;
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int HALF_LO     = 22;
    localparam int PP_BITS     = 2 * HALF_LO;
    localparam int PROD_BITS   = 2 * ACC_BITS;
    localparam int FRAC_SHIFT  = 30;
    localparam int ROOT_BITS   = 120;
    localparam int COEF_BITS   = 16;
    localparam int MUL_STEPS   = 8;
    localparam int MAX_ELEMENTS_DEF = 4096;

    // partial product selection within one 43 x 43 multiply
    localparam logic [1:0] PP_LL = 2'd0;
    localparam logic [1:0] PP_LH = 2'd1;
    localparam logic [1:0] PP_HL = 2'd2;
    localparam logic [1:0] PP_HH = 2'd3;

    typedef struct packed {
        logic       accum;      // take one element pair
        logic       check;      // clear product registers
        logic       mul_en;
        logic [2:0] mul_idx;
        logic       acc_en;
        logic [2:0] acc_idx;
        logic       prep;       // load root search registers
        logic       root_en;
        logic [3:0] root_bit;
        logic       emit;       // load result, clear sums
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic fit;
    } t_status;

endpackage

>>> sv/bvo_ctrl.sv
module bvo_ctrl import bvo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  logic    i_s_tlast,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        ST_ACCUM = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_PREP  = 6'b001000,
        ST_ROOT  = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_m_valid, n_m_valid;
    logic       w_emit_ok;

    assign w_emit_ok  = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_ACCUM);
    assign o_m_tvalid = r_m_valid;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_m_valid = r_m_valid && !i_m_tready;
        o_cmd     = '0;
        unique case (r_state)
            ST_ACCUM: begin
                if (i_s_tvalid) begin
                    o_cmd.accum = 1'b1;
                    if (i_s_tlast) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt       = '0;
                n_state     = i_st.degen ? ST_EMIT : ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_en  = (r_cnt != 4'(MUL_STEPS));
                o_cmd.mul_idx = r_cnt[2:0];
                o_cmd.acc_en  = (r_cnt != 4'd0);
                o_cmd.acc_idx = 3'(r_cnt - 4'd1);
                n_cnt         = r_cnt + 4'd1;
                if (r_cnt == 4'(MUL_STEPS)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = 4'd15;
                n_state    = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_en  = 1'b1;
                o_cmd.root_bit = r_cnt;
                n_cnt          = r_cnt - 4'd1;
                if ((i_st.fit && r_cnt == 4'd15) || r_cnt == 4'd0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_m_valid  = 1'b1;
                    n_state    = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_ACCUM;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

>>> sv/bvo_dp.sv
module bvo_dp import bvo_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [ACC_BITS-1:0]    i_cfg_wdata,
    input  logic [ELEM_BITS-1:0]   i_p_elem,
    input  logic [ELEM_BITS-1:0]   i_q_elem,
    input  t_cmd                   i_cmd,
    output t_status                o_st,
    output logic [COEF_BITS-1:0]   o_coefficient,
    output logic                   o_degenerate,
    output logic                   o_overflow
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

    logic [ACC_BITS-1:0]  r_floor;
    logic [ACC_BITS-1:0]  r_sum_pq, r_e1, r_e2;
    logic [CNT_W-1:0]     r_count;
    logic                 r_ovf;
    logic [PROD_BITS-1:0] r_prod_e, r_prod_a;
    logic [PP_BITS-1:0]   r_pp;
    logic [ROOT_BITS-1:0] r_s, r_u, r_v;
    logic [COEF_BITS-1:0] r_c;
    logic [COEF_BITS-1:0] r_coef;
    logic                 r_degen_o, r_ovf_o;

    logic [MAG_BITS-1:0]  w_pm, w_qm;
    logic [SQ_BITS-1:0]   w_pp2, w_qq2, w_pq;
    logic [ACC_BITS:0]    w_s1, w_s2, w_s3;
    logic [ACC_BITS-1:0]  w_x, w_y;
    logic [HALF_LO-1:0]   w_ma, w_mb;
    logic [PROD_BITS-1:0] w_pp_sh;
    logic [ROOT_BITS-1:0] w_t, w_a_full;

    assign w_pm  = i_p_elem[ELEM_BITS-1] ? (~i_p_elem + 1'b1) : i_p_elem;
    assign w_qm  = i_q_elem[ELEM_BITS-1] ? (~i_q_elem + 1'b1) : i_q_elem;
    assign w_pp2 = w_pm * w_pm;
    assign w_qq2 = w_qm * w_qm;
    assign w_pq  = w_pm * w_qm;
    assign w_s1  = {1'b0, r_e1} + (ACC_BITS+1)'(w_pp2);
    assign w_s2  = {1'b0, r_e2} + (ACC_BITS+1)'(w_qq2);
    assign w_s3  = {1'b0, r_sum_pq} + (ACC_BITS+1)'(w_pq);

    // shared partial product multiplier
    assign w_x = i_cmd.mul_idx[2] ? r_sum_pq : r_e1;
    assign w_y = i_cmd.mul_idx[2] ? r_sum_pq : r_e2;

    always_comb begin
        case (i_cmd.mul_idx[1:0])
            PP_LL: begin
                w_ma = w_x[HALF_LO-1:0];
                w_mb = w_y[HALF_LO-1:0];
            end
            PP_LH: begin
                w_ma = w_x[HALF_LO-1:0];
                w_mb = HALF_LO'(w_y[ACC_BITS-1:HALF_LO]);
            end
            PP_HL: begin
                w_ma = HALF_LO'(w_x[ACC_BITS-1:HALF_LO]);
                w_mb = w_y[HALF_LO-1:0];
            end
            default: begin
                w_ma = HALF_LO'(w_x[ACC_BITS-1:HALF_LO]);
                w_mb = HALF_LO'(w_y[ACC_BITS-1:HALF_LO]);
            end
        endcase
    end

    always_comb begin
        case (i_cmd.acc_idx[1:0])
            PP_LL:   w_pp_sh = PROD_BITS'(r_pp);
            PP_HH:   w_pp_sh = PROD_BITS'(r_pp) << (2 * HALF_LO);
            default: w_pp_sh = PROD_BITS'(r_pp) << HALF_LO;
        endcase
    end

    // trial square for the next coefficient bit
    assign w_a_full = ROOT_BITS'(r_prod_a) << FRAC_SHIFT;
    assign w_t      = r_s + r_u + r_v;

    assign o_st.degen = (r_e1 <= r_floor) || (r_e2 <= r_floor);
    assign o_st.fit   = (w_t <= w_a_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor  <= '0;
            r_sum_pq <= '0;
            r_e1     <= '0;
            r_e2     <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_floor <= i_cfg_wdata;
            end
            if (i_cmd.accum) begin
                r_e1     <= w_s1[ACC_BITS] ? ACC_MAX : w_s1[ACC_BITS-1:0];
                r_e2     <= w_s2[ACC_BITS] ? ACC_MAX : w_s2[ACC_BITS-1:0];
                r_sum_pq <= w_s3[ACC_BITS] ? ACC_MAX : w_s3[ACC_BITS-1:0];
                if (r_count < CNT_W'(MAX_ELEMENTS)) begin
                    r_count <= r_count + 1'b1;
                end
                // too many pairs or a sum clipped at full scale
                if ((r_count >= CNT_W'(MAX_ELEMENTS)) ||
                    w_s1[ACC_BITS] || w_s2[ACC_BITS] || w_s3[ACC_BITS]) begin
                    r_ovf <= 1'b1;
                end
            end else if (i_cmd.emit) begin
                r_e1     <= '0;
                r_e2     <= '0;
                r_sum_pq <= '0;
                r_count  <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_prod_e <= '0;
            r_prod_a <= '0;
        end else if (i_cmd.acc_en) begin
            if (i_cmd.acc_idx[2]) begin
                r_prod_a <= r_prod_a + w_pp_sh;
            end else begin
                r_prod_e <= r_prod_e + w_pp_sh;
            end
        end
        if (i_cmd.mul_en) begin
            r_pp <= w_ma * w_mb;
        end
        if (i_cmd.prep) begin
            r_s <= '0;
            r_u <= '0;
            r_v <= ROOT_BITS'(r_prod_e) << (2 * (COEF_BITS - 1));
            r_c <= '0;
        end else if (i_cmd.root_en) begin
            if (o_st.fit) begin
                r_s <= w_t;
                r_u <= (r_u + (r_v << 1)) >> 1;
                r_c[i_cmd.root_bit] <= 1'b1;
            end else begin
                r_u <= r_u >> 1;
            end
            r_v <= r_v >> 2;
        end
        if (i_cmd.emit) begin
            r_coef    <= o_st.degen ? '0 : r_c;
            r_degen_o <= o_st.degen;
            r_ovf_o   <= r_ovf;
        end
    end

    assign o_coefficient = r_coef;
    assign o_degenerate  = r_degen_o;
    assign o_overflow    = r_ovf_o;

endmodule

>>> sv/bhattacharyya_vector_overlap.sv
// one element pair per cycle while a vector streams in; p*p, q*q and p*q accumulated per pair
// after the last pair: floor check, eight partial products on the shared 22x22 multiplier,
// setup, a bit-by-bit root search over up to 16 coefficient bits, then the output
// register; a degenerate vector skips straight from the check to the output
// input is stalled only during that tail, which waits while an earlier result is not taken
// reset (i_rst_n low, synchronous) clears sums, counter, flags and zero_floor
module bhattacharyya_vector_overlap import bvo_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: zero_floor
    input  logic                  i_cfg_we,
    input  logic [ACC_BITS-1:0]   i_cfg_wdata,
    // request side
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [31:0]           i_s_tdata,   // [15:0] p_elem, [31:16] q_elem
    input  logic                  i_s_tlast,   // last element pair
    // result side
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [15:0]           o_m_tdata,   // [15:0] coefficient
    output logic [1:0]            o_m_tuser    // [0] degenerate, [1] overflow
);

    t_cmd    w_cmd;
    t_status w_st;

    // sequencing of accumulate, multiply, root search and hand-off
    bvo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // sums, wide products and the square root search
    bvo_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_p_elem      (i_s_tdata[15:0]),
        .i_q_elem      (i_s_tdata[31:16]),
        .i_cmd         (w_cmd),
        .o_st          (w_st),
        .o_coefficient (o_m_tdata),
        .o_degenerate  (o_m_tuser[0]),
        .o_overflow    (o_m_tuser[1])
    );

endmodule
